FILE: rtl/indexed_doubly_linked_list_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed doubly linked list
// Shared clocked assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_TOP_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_TOP_MACROS_SVH

// Clocked property, switched off while reset is high
`define IDLL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must hold in reset too
`define IDLL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Types, widths and operation codes shared by the linked list block.
// ----------------------------------------------------------------------------
`default_nettype none

package idll_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int KIND_W     = 3;

  localparam logic [KIND_W-1:0] KIND_ADD_FIRST    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_LAST     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_BEFORE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT         = 3'd5;

  // A link is null when valid is low; null is kept all zero
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } link_t;

  localparam int    LINK_W   = $bits(link_t);
  localparam link_t LINK_NIL = '0;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_addr;
    link_t             prev_data;
    logic              next_we;
    logic [SLOT_W-1:0] next_addr;
    link_t             next_data;
  } mem_ctl_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic              result_valid;
    logic [SLOT_W-1:0] first_slot;
    logic              first_valid;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/idll_ram.sv
// ----------------------------------------------------------------------------
// idll_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_ram #(
  parameter int WIDTH  = 9,
  parameter int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/idll_engine.sv
// ----------------------------------------------------------------------------
// idll_engine
// Sequencer that reads a slot's links, decides the operation and writes the
// neighbour links back; owns the head, tail and count registers.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_engine
  import idll_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output      logic              req_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [SLOT_W-1:0] anchor_slot,
  input  wire link_t             prev_rd,
  input  wire link_t             next_rd,
  output      mem_ctl_t          mem,
  output      logic              done_valid,
  input  wire logic              done_take,
  output      rsp_t              done
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOK   = 3'd2;
  localparam logic [2:0] ST_LOOK_A = 3'd3;
  localparam logic [2:0] ST_EXEC   = 3'd4;
  localparam logic [2:0] ST_WR2    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] clr_cnt, clr_cnt_next;
  link_t             head, head_next;
  link_t             tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic              res_valid, res_valid_next;

  logic [KIND_W-1:0] op;
  logic [SLOT_W-1:0] tgt;
  logic [SLOT_W-1:0] anc;
  link_t             ps, ns, pa;
  logic              lnk_s, lnk_a;

  logic              anc_is_head;

  assign anc_is_head = head.valid && (head.slot == anc);

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    res_slot_next  = res_slot;
    res_valid_next = res_valid;
    mem            = '0;

    unique case (state)
      ST_CLEAR: begin
        mem.prev_we   = 1'b1;
        mem.next_we   = 1'b1;
        mem.prev_addr = clr_cnt;
        mem.next_addr = clr_cnt;
        mem.prev_data = LINK_NIL;
        mem.next_data = LINK_NIL;
        clr_cnt_next  = clr_cnt + SLOT_W'(1);
        if (clr_cnt == SLOT_W'(SLOT_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem.rd_en   = req_valid;
        mem.rd_addr = (kind == KIND_REMOVE_FIRST) ? head.slot : slot;
        if (req_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (op == KIND_ADD_BEFORE) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = anc;
          state_next  = ST_LOOK_A;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_LOOK_A: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        res_slot_next  = '0;
        res_valid_next = 1'b0;
        state_next     = ST_DONE;
        unique case (op) inside
          KIND_ADD_FIRST: begin
            if (!lnk_s) begin
              if (head.valid) begin
                mem.next_we   = 1'b1;
                mem.next_addr = tgt;
                mem.next_data = head;
                mem.prev_we   = 1'b1;
                mem.prev_addr = head.slot;
                mem.prev_data = '{valid: 1'b1, slot: tgt};
              end else begin
                tail_next = '{valid: 1'b1, slot: tgt};
              end
              head_next  = '{valid: 1'b1, slot: tgt};
              count_next = count + CNT_W'(1);
            end
          end
          KIND_ADD_LAST: begin
            if (!lnk_s) begin
              if (tail.valid) begin
                mem.prev_we   = 1'b1;
                mem.prev_addr = tgt;
                mem.prev_data = tail;
                mem.next_we   = 1'b1;
                mem.next_addr = tail.slot;
                mem.next_data = '{valid: 1'b1, slot: tgt};
              end else begin
                head_next = '{valid: 1'b1, slot: tgt};
              end
              tail_next  = '{valid: 1'b1, slot: tgt};
              count_next = count + CNT_W'(1);
            end
          end
          KIND_ADD_BEFORE: begin
            if (!lnk_s && lnk_a) begin
              if (anc_is_head) begin
                // anchor leads the list: same as a push at the front
                mem.next_we   = 1'b1;
                mem.next_addr = tgt;
                mem.next_data = head;
                mem.prev_we   = 1'b1;
                mem.prev_addr = head.slot;
                mem.prev_data = '{valid: 1'b1, slot: tgt};
                head_next     = '{valid: 1'b1, slot: tgt};
                count_next    = count + CNT_W'(1);
              end else if (pa.valid) begin
                mem.prev_we   = 1'b1;
                mem.prev_addr = anc;
                mem.prev_data = '{valid: 1'b1, slot: tgt};
                mem.next_we   = 1'b1;
                mem.next_addr = tgt;
                mem.next_data = '{valid: 1'b1, slot: anc};
                count_next    = count + CNT_W'(1);
                state_next    = ST_WR2;
              end
            end
          end
          KIND_REMOVE, KIND_REMOVE_FIRST: begin
            if ((op == KIND_REMOVE) ? lnk_s : head.valid) begin
              if (ps.valid) begin
                mem.next_we   = 1'b1;
                mem.next_addr = ps.slot;
                mem.next_data = ns;
              end else begin
                head_next = ns;
              end
              if (ns.valid) begin
                mem.prev_we   = 1'b1;
                mem.prev_addr = ns.slot;
                mem.prev_data = ps;
              end else begin
                tail_next = ps;
              end
              count_next = (count != '0) ? count - CNT_W'(1) : count;
              if (op == KIND_REMOVE_FIRST) begin
                res_slot_next  = tgt;
                res_valid_next = 1'b1;
              end
              state_next = ST_WR2;
            end
          end
          KIND_NEXT: begin
            if (ns.valid) begin
              res_slot_next  = ns.slot;
              res_valid_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_WR2: begin
        state_next  = ST_DONE;
        mem.prev_we = 1'b1;
        mem.next_we = 1'b1;
        if (op == KIND_ADD_BEFORE) begin
          mem.next_addr = pa.slot;
          mem.next_data = '{valid: 1'b1, slot: tgt};
          mem.prev_addr = tgt;
          mem.prev_data = pa;
        end else begin
          // drop the removed slot's own links
          mem.prev_addr = tgt;
          mem.prev_data = LINK_NIL;
          mem.next_addr = tgt;
          mem.next_data = LINK_NIL;
        end
      end
      ST_DONE: begin
        if (done_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      head      <= LINK_NIL;
      tail      <= LINK_NIL;
      count     <= '0;
      res_slot  <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      res_slot  <= res_slot_next;
      res_valid <= res_valid_next;
    end
  end

  // capture the request and the links read back
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      op  <= kind;
      tgt <= (kind == KIND_REMOVE_FIRST) ? head.slot : slot;
      anc <= anchor_slot;
    end
    if (state == ST_LOOK) begin
      ps    <= prev_rd;
      ns    <= next_rd;
      lnk_s <= prev_rd.valid || next_rd.valid || (head.valid && head.slot == tgt);
    end
    if (state == ST_LOOK_A) begin
      pa    <= prev_rd;
      lnk_a <= prev_rd.valid || next_rd.valid || anc_is_head;
    end
  end

  assign req_stall         = (state != ST_IDLE);
  assign done_valid        = (state == ST_DONE);
  assign done.result_slot  = res_slot;
  assign done.result_valid = res_valid;
  assign done.first_slot   = head.slot;
  assign done.first_valid  = head.valid;
  assign done.entry_count  = count;

endmodule

`default_nettype wire

FILE: rtl/indexed_doubly_linked_list_top.sv
// Doubly linked list over a pool of 256 slots, kept in two link RAMs
// (previous and next) with head, tail and count in registers. Each request
// carries one of six operations and returns exactly one response with the
// lookup result, the first slot and the count after the operation. After
// reset the block sweeps both link RAMs to null and holds req_stall high
// meanwhile. One request is in flight at a time. After a request is accepted
// the block does a registered read of the slot's links, decides and writes,
// then loads the output register. Unlinking a linked slot (remove or pop)
// adds a step to clear the removed slot's own links; insert-before adds a
// second read for the anchor's links and, when the anchor is not the head,
// a second write. req_stall drops in the cycle the response appears, so a
// new request is taken while that response still waits in the output
// register.
`default_nettype none

module indexed_doubly_linked_list_top
  import idll_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output      logic              req_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [SLOT_W-1:0] anchor_slot,
  output      logic              rsp_valid,
  input  wire logic              rsp_stall,
  output      logic [SLOT_W-1:0] result_slot,
  output      logic              result_valid,
  output      logic [SLOT_W-1:0] first_slot,
  output      logic              first_valid,
  output      logic [CNT_W-1:0]  entry_count
);

  mem_ctl_t          mem;
  logic [LINK_W-1:0] prev_q;
  logic [LINK_W-1:0] next_q;
  logic              done_valid;
  logic              done_take;
  rsp_t              done;

  idll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOT_COUNT)
  ) u_prev_ram (
    .clk     (clk),
    .we      (mem.prev_we),
    .wr_addr (mem.prev_addr),
    .wr_data (mem.prev_data),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (prev_q)
  );

  idll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOT_COUNT)
  ) u_next_ram (
    .clk     (clk),
    .we      (mem.next_we),
    .wr_addr (mem.next_addr),
    .wr_data (mem.next_data),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (next_q)
  );

  idll_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .slot        (slot),
    .anchor_slot (anchor_slot),
    .prev_rd     (link_t'(prev_q)),
    .next_rd     (link_t'(next_q)),
    .mem         (mem),
    .done_valid  (done_valid),
    .done_take   (done_take),
    .done        (done)
  );

  // output register: load when empty or being drained
  assign done_take = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_take) begin
      rsp_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_take && done_valid) begin
      result_slot  <= done.result_slot;
      result_valid <= done.result_valid;
      first_slot   <= done.first_slot;
      first_valid  <= done.first_valid;
      entry_count  <= done.entry_count;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/idll_checker.sv
// ----------------------------------------------------------------------------
// idll_checker
// Port-level checks on the linked list responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_doubly_linked_list_top_macros.svh"

module idll_checker
  import idll_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_stall,
  input wire logic [KIND_W-1:0] kind,
  input wire logic [SLOT_W-1:0] slot,
  input wire logic [SLOT_W-1:0] anchor_slot,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire logic [SLOT_W-1:0] result_slot,
  input wire logic              result_valid,
  input wire logic [SLOT_W-1:0] first_slot,
  input wire logic              first_valid,
  input wire logic [CNT_W-1:0]  entry_count
);

  `IDLL_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(result_slot) && $stable(first_slot) && $stable(entry_count), "stalled response changed")
  `IDLL_ASSERT(a_result_zero, rsp_valid && !result_valid |-> result_slot == '0, "result slot not zero without a result")
  `IDLL_ASSERT(a_first_zero, rsp_valid && !first_valid |-> first_slot == '0, "first slot not zero on an empty list")
  `IDLL_ASSERT_ALWAYS(a_count_range, rsp_valid |-> entry_count <= CNT_W'(SLOT_COUNT), "count beyond the pool size")

endmodule

bind indexed_doubly_linked_list_top idll_checker u_idll_checker (.*);

`default_nettype wire
